FILE: rtl/sit_block_decrypt_defines.svh
// ----------------------------------------------------------------------------
// sit_block_decrypt_defines.svh
// Assertion macros for the SIT block decrypt RTL.
// ----------------------------------------------------------------------------
`ifndef SIT_BLOCK_DECRYPT_DEFINES_SVH
`define SIT_BLOCK_DECRYPT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define SBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SBD_ASSERT(label, prop, msg)
`define SBD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Types, constants and the F function of the SIT block decrypt.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int unsigned BLOCK_W   = 64;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned NUM_KEYS  = 5;
  localparam int unsigned KEY_IDX_W = 3;

  typedef logic [WORD_W-1:0] word_t;

  // word order matches the block packing: w4 in the top bits, w1 at the bottom
  typedef struct packed {
    word_t w4;
    word_t w3;
    word_t w2;
    word_t w1;
  } quad_t;

  typedef word_t [NUM_KEYS-1:0] key_arr_t;

  localparam key_arr_t KEY_RESET = {16'h0123, 16'hcdef, 16'h89ab, 16'h4567, 16'h0123};

  localparam logic [3:0] SBOX_P [16] = '{4'd3, 4'd15, 4'd14, 4'd0, 4'd5, 4'd4, 4'd11, 4'd12,
                                         4'd13, 4'd10, 4'd9, 4'd6, 4'd7, 4'd8, 4'd2, 4'd1};
  localparam logic [3:0] SBOX_Q [16] = '{4'd9, 4'd14, 4'd5, 4'd6, 4'd10, 4'd2, 4'd3, 4'd12,
                                         4'd15, 4'd0, 4'd4, 4'd13, 4'd7, 4'd11, 4'd1, 4'd8};

  function automatic logic [3:0] sbox_p(input logic [3:0] x);
    return SBOX_P[x];
  endfunction

  function automatic logic [3:0] sbox_q(input logic [3:0] x);
    return SBOX_Q[x];
  endfunction

  // F: three S-box layers, nibble halves crossed between layers
  function automatic word_t mix_word(input word_t w);
    logic [3:0] a0, b0, c0, e0;
    logic [3:0] a1, b1, c1, e1;
    logic [3:0] a2, b2, c2, e2;
    a0 = sbox_p(w[15:12]);
    b0 = sbox_q(w[11:8]);
    c0 = sbox_p(w[7:4]);
    e0 = sbox_q(w[3:0]);

    b1 = sbox_q({a0[3:2], b0[3:2]});
    a1 = sbox_p({a0[1:0], c0[3:2]});
    e1 = sbox_q({b0[1:0], e0[3:2]});
    c1 = sbox_p({c0[1:0], e0[1:0]});

    a2 = sbox_p({b1[3:2], a1[3:2]});
    b2 = sbox_q({b1[1:0], e1[3:2]});
    c2 = sbox_p({a1[1:0], c1[3:2]});
    e2 = sbox_q({e1[1:0], c1[1:0]});
    return {a2, b2, c2, e2};
  endfunction

endpackage

FILE: rtl/sbd_channels_if.sv
// ----------------------------------------------------------------------------
// sbd_channels_if
// Valid/ready channels for ciphertext and plaintext blocks.
// ----------------------------------------------------------------------------
interface sbd_cipher_if;
  logic                        valid;
  logic                        ready;
  logic [sbd_pkg::BLOCK_W-1:0] cipher_block;

  modport source (output valid, output cipher_block, input ready);
  modport sink   (input valid, input cipher_block, output ready);
endinterface

interface sbd_plain_if;
  logic                        valid;
  logic                        ready;
  logic [sbd_pkg::BLOCK_W-1:0] plain_block;

  modport source (output valid, output plain_block, input ready);
  modport sink   (input valid, input plain_block, output ready);
endinterface

FILE: rtl/sit_block_decrypt.sv
// ----------------------------------------------------------------------------
// sit_block_decrypt
// Datapath: an accepted block is held in the input reg, runs through the
// unrolled rounds and is registered in the result reg before it is offered.
// Throughput: one block per cycle; all rounds are unrolled between the regs.
// Stalls on the output back up through both stages with no bubbles.
// Reset (async, active low) empties both stages and loads the default keys.
// ----------------------------------------------------------------------------
module sit_block_decrypt #(
  parameter int unsigned ROUNDS = 5  // 1..5, round g uses key ROUNDS-1-g
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sbd_cipher_if.sink                    cipher_i,
  sbd_plain_if.source                   plain_o,
  input  logic                          cfg_we_i,
  input  logic [sbd_pkg::KEY_IDX_W-1:0] cfg_idx_i,
  input  sbd_pkg::word_t                cfg_data_i
);
  import sbd_pkg::*;

  `include "sit_block_decrypt_defines.svh"

  // --------------------------------------------------------------------------
  // Round keys
  // --------------------------------------------------------------------------
  key_arr_t keys;

  sbd_key_regs u_keys (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .keys_o     (keys)
  );

  // --------------------------------------------------------------------------
  // Stage control: each stage loads when it is empty or its consumer moves.
  // --------------------------------------------------------------------------
  logic  in_valid_q, in_valid_d;
  quad_t in_blk_q;
  logic  out_valid_q, out_valid_d;
  quad_t out_blk_q;
  logic  out_load;
  logic  in_load;

  assign out_load       = !out_valid_q || plain_o.ready;
  assign in_load        = !in_valid_q || out_load;
  assign cipher_i.ready = in_load;

  always_comb begin
    in_valid_d  = in_load ? cipher_i.valid : in_valid_q;
    out_valid_d = out_load ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Unrolled rounds; stage g applies key ROUNDS-1-g (last key goes first).
  // --------------------------------------------------------------------------
  quad_t rnd_w [ROUNDS+1];
  quad_t res;

  assign rnd_w[0] = in_blk_q;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    sbd_round u_round (
      .w_i   (rnd_w[g]),
      .key_i (keys[ROUNDS-1-g]),
      .w_o   (rnd_w[g+1])
    );
  end

  // result is the last round's words before its permutation
  always_comb begin
    res.w1 = rnd_w[ROUNDS].w2;
    res.w2 = rnd_w[ROUNDS].w1;
    res.w3 = rnd_w[ROUNDS].w4;
    res.w4 = rnd_w[ROUNDS].w3;
  end

  // payload regs, no reset
  always_ff @(posedge clk_i) begin
    if (in_load && cipher_i.valid) begin
      in_blk_q <= quad_t'(cipher_i.cipher_block);
    end
    if (out_load && in_valid_q) begin
      out_blk_q <= res;
    end
  end

  assign plain_o.valid       = out_valid_q;
  assign plain_o.plain_block = BLOCK_W'(out_blk_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SBD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!in_valid_q && !out_valid_q), "valid in reset")
  `SBD_ASSERT(a_advance, (in_valid_q && out_load) |=> out_valid_q, "item lost between stages")
  `SBD_ASSERT(a_in_hold, !in_load |=> in_valid_q && $stable(in_blk_q), "stalled input changed")
  `SBD_ASSERT(a_ready_empty, !out_valid_q |-> cipher_i.ready, "not ready with empty result stage")

endmodule

FILE: rtl/sbd_key_regs.sv
// ----------------------------------------------------------------------------
// sbd_key_regs
// Round key register file, written through the config port.
// ----------------------------------------------------------------------------
module sbd_key_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbd_pkg::KEY_IDX_W-1:0]   cfg_idx_i,
  input  sbd_pkg::word_t                  cfg_data_i,
  output sbd_pkg::key_arr_t               keys_o
);
  import sbd_pkg::*;

  key_arr_t keys_q;

  // writes beyond the last key are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= KEY_RESET;
    end else if (cfg_we_i && (cfg_idx_i < KEY_IDX_W'(NUM_KEYS))) begin
      keys_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign keys_o = keys_q;

endmodule

FILE: rtl/sbd_round.sv
// ----------------------------------------------------------------------------
// sbd_round
// One decryption round: key XNOR on words 1 and 4, F cross-mix, permute.
// ----------------------------------------------------------------------------
module sbd_round (
  input  sbd_pkg::quad_t w_i,
  input  sbd_pkg::word_t key_i,
  output sbd_pkg::quad_t w_o
);
  import sbd_pkg::*;

  word_t n1, n2, n3, n4;

  always_comb begin
    n1 = ~(w_i.w1 ^ key_i);
    n2 = mix_word(w_i.w4) ^ w_i.w3;
    n4 = ~(w_i.w4 ^ key_i);
    n3 = mix_word(w_i.w1) ^ w_i.w2;
    // word permutation for the following round
    w_o.w1 = n2;
    w_o.w2 = n1;
    w_o.w3 = n4;
    w_o.w4 = n3;
  end

endmodule
